[sv/ptw_pkg.sv]
// Types and constants shared by the four-level page table walker.
package ptw_pkg;

    localparam int VADDR_W = 48;
    localparam int PADDR_W = 52;
    localparam int ENTRY_W = 64;
    localparam int FRAME_W = 51;
    localparam int IDX_W   = 9;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_ENTRY     = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDP  = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    localparam int VALID_BIT = 0;
    localparam int LARGE_BIT = 7;

    typedef struct packed {
        logic               op;
        logic [VADDR_W-1:0] virt_addr;
        logic [ENTRY_W-1:0] table_entry;
    } t_ptw_req;

    typedef struct packed {
        logic               kind;
        logic [PADDR_W-1:0] read_addr;
        logic               mapped;
        logic               huge_page;
        logic [FRAME_W-1:0] frame_number;
        logic               protocol_error;
    } t_ptw_rsp;

    typedef struct packed {
        logic               busy;
        logic [1:0]         level;
        logic [VADDR_W-1:0] vaddr;
    } t_ptw_state;

endpackage

[sv/ptw_step.sv]
// One walk step: next walk state and result for one request.
module ptw_step #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  ptw_pkg::t_ptw_req   i_req,
    input  ptw_pkg::t_ptw_state i_state,
    input  logic [51:0]         i_root_base,
    output ptw_pkg::t_ptw_state o_state,
    output ptw_pkg::t_ptw_rsp   o_rsp
);
    import ptw_pkg::*;

    localparam logic [PADDR_W-1:0] PADDR_MASK = {PADDR_W{1'b1}} >> (PADDR_W - PHYS_ADDR_BITS);

    logic [VADDR_W-1:0] vaddr;
    logic [1:0]         level;
    logic [IDX_W-1:0]   idx;
    logic [PADDR_W-13:0] table_hi;
    logic [ENTRY_W-1:0] e;

    always_comb begin
        e = i_req.table_entry;
        o_state = i_state;
        o_rsp = '0;
        vaddr = i_state.vaddr;
        level = i_state.level;
        table_hi = e[PADDR_W-1:12];
        if (i_req.op == OP_TRANSLATE) begin
            vaddr = i_req.virt_addr;
            level = LVL_PML4;
            table_hi = i_root_base[PADDR_W-1:12];
            o_state.busy = 1'b1;
            o_state.level = LVL_PML4;
            o_state.vaddr = i_req.virt_addr;
            o_rsp.kind = KIND_READ;
            o_rsp.protocol_error = i_state.busy;
        end else if (!i_state.busy) begin
            o_rsp.kind = KIND_DONE;
            o_rsp.protocol_error = 1'b1;
        end else if (!e[VALID_BIT]) begin
            o_state.busy = 1'b0;
            o_state.level = LVL_PML4;
            o_rsp.kind = KIND_DONE;
        end else if (i_state.level == LVL_PD && e[LARGE_BIT]) begin
            o_state.busy = 1'b0;
            o_state.level = LVL_PML4;
            o_rsp.kind = KIND_DONE;
            o_rsp.mapped = 1'b1;
            o_rsp.huge_page = 1'b1;
            o_rsp.frame_number = e[62:12];
        end else if (i_state.level == LVL_PT) begin
            o_state.busy = 1'b0;
            o_state.level = LVL_PML4;
            o_rsp.kind = KIND_DONE;
            o_rsp.mapped = 1'b1;
            o_rsp.frame_number = e[62:12];
        end else begin
            level = i_state.level + 2'd1;
            o_state.level = level;
            o_rsp.kind = KIND_READ;
        end

        case (level)
            LVL_PML4: idx = vaddr[47:39];
            LVL_PDP:  idx = vaddr[38:30];
            LVL_PD:   idx = vaddr[29:21];
            LVL_PT:   idx = vaddr[20:12];
            default:  idx = '0;
        endcase

        if (o_rsp.kind == KIND_READ) begin
            o_rsp.read_addr = {table_hi, idx, 3'b000} & PADDR_MASK;
        end
    end

endmodule

[sv/four_level_page_table_walker.sv]
// Top level of the four-level page table walker.
//
// Request channel (i_in_valid / o_in_stall / i_in_req): a translate request
// starts a walk from the root table; an entry request hands back the table
// entry read at the address the walker last asked for.
// Result channel (o_out_valid / i_out_stall / o_out_rsp): exactly one result
// per request, either a memory read request for the next entry or a
// finished translation with frame number, large-page and error flags.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the
// root table base; write it only while no walk result is outstanding.
// The request is held in the input register and moves to the result
// register once the result register is free. Throughput is one request per
// cycle while the receiver does not stall. The walk state is updated as
// each request leaves the input register.
// When the receiver stalls, the result register holds, then the input
// register holds, and o_in_stall rises. Synchronous active-low reset empties
// both registers, clears the root base and returns the walker to idle.
module four_level_page_table_walker #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ptw_pkg::t_ptw_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ptw_pkg::t_ptw_rsp o_out_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [51:0]       i_cfg_data
);
    import ptw_pkg::*;

    logic       r_in_valid;
    t_ptw_req   r_in_req;
    logic       r_out_valid;
    t_ptw_rsp   r_out_rsp;
    t_ptw_state r_state;
    t_ptw_state n_state;
    t_ptw_rsp   n_rsp;
    logic [PADDR_W-1:0] r_root_base;
    logic       out_free;
    logic       step_go;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign step_go     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;
    assign o_cfg_ready = 1'b1;

    ptw_step #(
        .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
    ) u_step (
        .i_req       (r_in_req),
        .i_state     (r_state),
        .i_root_base (r_root_base),
        .o_state     (n_state),
        .o_rsp       (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_root_base <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_root_base <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (step_go) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_req <= i_in_req;
        end
        if (step_go) begin
            r_out_rsp <= n_rsp;
        end
    end

endmodule
